/* src/ple_pkg.sv */
package ple_pkg;

   // List depth and the widths that follow from it.
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels.
   localparam int ACTION_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 6;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] item_value;
      logic [COUNT_OUT_W-1:0]    entry_count;
      logic                      last;
   } rsp_type;

endpackage

/* src/ple_req_if.sv */
interface ple_req_if;
   import ple_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/ple_rsp_if.sv */
interface ple_rsp_if;
   import ple_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/ple_ram.sv */
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data is registered and holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/positional_list_engine.sv */
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Requests arrive on req_chan as valid/ready transactions carrying an action, a
// value and a 1-based position; results leave on rsp_chan the same way.
// An insert or a delete returns one result transaction; a dump returns one
// transaction per stored entry, front to back, with last set on the final one
// (an empty list gives a single transaction). Every result carries the count.
// The entries live in one single-port-write, registered-read RAM, so an insert
// or delete moves the entries behind its position one per cycle. With the
// receiver ready, an insert reads each moved entry and writes it one place
// higher before it writes the new value, and a delete reads the removed value
// before it moves each later entry down one place. A dump reads its entries
// front to back, one per cycle. A new request is accepted only after the
// previous one has handed its last result to the output register, so the
// engine never works on two requests at once.
// Synchronous reset empties the list and drops any pending result; the RAM is
// not cleared, since only entries below the count are ever read.
// When the receiver stalls, the output register holds its transaction and the
// engine waits; a dump pauses its RAM reads until the register frees up.
module positional_list_engine (
   input  logic   clock,
   input  logic   reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);

   import ple_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SHUP = 3'd1;
   localparam logic [2:0] S_DEL  = 3'd2;
   localparam logic [2:0] S_DUMP = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ADDR_W-1:0]         ptr_ff, ptr_in;
   logic                      more_ff, more_in;
   logic                      pv_ff, pv_in;
   logic [ADDR_W-1:0]         pa_ff, pa_in;
   logic [ADDR_W-1:0]         k_ff, k_in;
   logic [VALUE_W-1:0]        val_ff, val_in;
   logic [VALUE_W-1:0]        got_ff, got_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      dv_ff, dv_in;
   logic [ADDR_W-1:0]         di_ff, di_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   rsp_type                   rsp_dat_ff, rsp_dat_in;

   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [VALUE_W-1:0]        ram_wr_data;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [VALUE_W-1:0]        ram_rd_data;

   logic                      accept;
   logic                      out_free;
   logic                      out_load;
   logic [ADDR_W-1:0]         last_addr;
   logic [CMP_W-1:0]          pos_x;
   logic [CMP_W-1:0]          cnt_x;

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_dat_ff;

   // The output register can take a new transaction when it is empty or
   // being drained in this cycle.
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign last_addr = ADDR_W'(count_ff - CNT_W'(1));
   assign pos_x     = CMP_W'(req_chan.payload.position);
   assign cnt_x     = CMP_W'(count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      more_in     = more_ff;
      pv_in       = 1'b0;
      pa_in       = pa_ff;
      k_in        = k_ff;
      val_in      = val_ff;
      got_in      = got_ff;
      status_in   = status_ff;
      dv_in       = dv_ff;
      di_in       = di_ff;
      rsp_dat_in  = rsp_dat_ff;
      out_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pa_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in    = req_chan.payload.value;
               k_in      = ADDR_W'(req_chan.payload.position - POS_W'(1));
               got_in    = '0;
               status_in = STAT_OK;
               dv_in     = 1'b0;
               unique case (req_chan.payload.action)
                  ACT_INSERT: begin
                     if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                        status_in = STAT_BAD_POS;
                        state_in  = S_RESP;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                        state_in  = S_RESP;
                     end else begin
                        // Walk from the back of the list toward the insert point.
                        ptr_in   = last_addr;
                        more_in  = (pos_x != cnt_x + CMP_W'(1));
                        state_in = S_SHUP;
                     end
                  end
                  ACT_DELETE: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = STAT_BAD_POS;
                        state_in  = S_RESP;
                     end else begin
                        ptr_in   = ADDR_W'(req_chan.payload.position - POS_W'(1));
                        more_in  = 1'b1;
                        state_in = S_DEL;
                     end
                  end
                  ACT_DUMP: begin
                     if (count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        ptr_in   = '0;
                        more_in  = 1'b1;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     status_in = STAT_BAD_POS;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end

         S_SHUP: begin
            // Read entry j, and in the next cycle write it back at j + 1.
            if (more_ff) begin
               ram_rd_en = 1'b1;
               pv_in     = 1'b1;
               pa_in     = ptr_ff;
               if (ptr_ff == k_ff) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - ADDR_W'(1);
               end
            end
            if (pv_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pa_ff + ADDR_W'(1);
            end else if (!more_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = k_ff;
               ram_wr_data = val_ff;
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_RESP;
            end
         end

         S_DEL: begin
            // The first read returns the removed value; each later entry moves
            // down one place.
            if (more_ff) begin
               ram_rd_en = 1'b1;
               pv_in     = 1'b1;
               pa_in     = ptr_ff;
               if (ptr_ff == last_addr) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + ADDR_W'(1);
               end
            end
            if (pv_ff) begin
               if (pa_ff == k_ff) begin
                  got_in = ram_rd_data;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pa_ff - ADDR_W'(1);
               end
            end else if (!more_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end

         S_DUMP: begin
            // The RAM read register doubles as the holding stage; a new read is
            // issued only once the held entry moves to the output register.
            out_load = dv_ff && out_free;
            if (more_ff && (!dv_ff || out_load)) begin
               ram_rd_en = 1'b1;
               dv_in     = 1'b1;
               di_in     = ptr_ff;
               if (ptr_ff == last_addr) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + ADDR_W'(1);
               end
            end else if (out_load) begin
               dv_in = 1'b0;
            end
            if (out_load) begin
               rsp_dat_in.status      = STAT_OK;
               rsp_dat_in.item_value  = ram_rd_data;
               rsp_dat_in.entry_count = COUNT_OUT_W'(count_ff);
               rsp_dat_in.last        = (di_ff == last_addr);
               if (di_ff == last_addr) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               out_load               = 1'b1;
               rsp_dat_in.status      = status_ff;
               rsp_dat_in.item_value  = got_ff;
               rsp_dat_in.entry_count = COUNT_OUT_W'(count_ff);
               rsp_dat_in.last        = 1'b1;
               state_in               = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         more_ff    <= 1'b0;
         pv_ff      <= 1'b0;
         dv_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         more_ff    <= more_in;
         pv_ff      <= pv_in;
         dv_ff      <= dv_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      pa_ff      <= pa_in;
      k_ff       <= k_in;
      val_ff     <= val_in;
      got_ff     <= got_in;
      status_ff  <= status_in;
      di_ff      <= di_in;
      rsp_dat_ff <= rsp_dat_in;
   end

`ifndef NO_ASSERTIONS
   // The move sequence never reads and writes the same entry in one cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("RAM read and write hit the same entry");

   // Writes stay within the list, one past its current end at most.
   a_wr_in_list: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CNT_W'(ram_wr_addr) <= count_ff))
      else $error("RAM write beyond the end of the list");

   // The count moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff))
             || (count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
             || (count_ff == CNT_W'($past(count_ff) - CNT_W'(1))))
      else $error("entry count jumped");

   // A held dump entry always lies inside the list.
   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP && dv_ff) |-> (CNT_W'(di_ff) < count_ff))
      else $error("dump index outside the list");

   // A result is loaded only into a free output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_chan.ready) |=> (rsp_dat_ff == $past(rsp_dat_ff)))
      else $error("pending result overwritten");
`endif

endmodule
